### rtl/core/rpos_pkg.sv
// Shared word types and vertex class codes for the rectangle pair overlap splitter.
package rpos_pkg;

  typedef enum logic [1:0] {
    CLS_START   = 2'd1,
    CLS_END     = 2'd2,
    CLS_NOTHING = 2'd3
  } cls_e;

  typedef struct packed {
    logic signed [31:0] a_left;
    logic signed [31:0] a_bottom;
    logic signed [31:0] a_right;
    logic signed [31:0] a_top;
    logic signed [31:0] b_left;
    logic signed [31:0] b_bottom;
    logic signed [31:0] b_right;
    logic signed [31:0] b_top;
  } in_word_t;

  typedef struct packed {
    logic               overlap;
    logic signed [31:0] tile_left;
    logic signed [31:0] tile_bottom;
    logic signed [31:0] tile_right;
    logic signed [31:0] tile_top;
    logic               last;
  } out_word_t;

endpackage

### rtl/core/rpos_vstore.sv
// Vertex register file: one write port with split coordinate and class enables, one read port.
module rpos_vstore #(
  parameter int Depth = 16,
  parameter int Cw    = 32,
  parameter int Aw    = 4
) (
  input  logic                  clk_i,
  input  logic                  wr_xy_en_i,
  input  logic                  wr_cls_en_i,
  input  logic [Aw-1:0]         wr_addr_i,
  input  logic signed [Cw-1:0]  wr_x_i,
  input  logic signed [Cw-1:0]  wr_y_i,
  input  rpos_pkg::cls_e        wr_cls_i,
  input  logic [Aw-1:0]         rd_addr_i,
  output logic signed [Cw-1:0]  rd_x_o,
  output logic signed [Cw-1:0]  rd_y_o,
  output rpos_pkg::cls_e        rd_cls_o
);
  import rpos_pkg::*;

  logic signed [Cw-1:0] x_q [Depth];
  logic signed [Cw-1:0] y_q [Depth];
  cls_e                 cls_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_xy_en_i) begin
      x_q[wr_addr_i] <= wr_x_i;
      y_q[wr_addr_i] <= wr_y_i;
    end
    if (wr_cls_en_i) begin
      cls_q[wr_addr_i] <= wr_cls_i;
    end
  end

  assign rd_x_o   = x_q[rd_addr_i];
  assign rd_y_o   = y_q[rd_addr_i];
  assign rd_cls_o = cls_q[rd_addr_i];

endmodule

### rtl/core/rect_pair_overlap_splitter_core.sv
// Top level of the rectangle pair overlap splitter: sequencer, scan unit and output register.
//
// The input channel carries one word holding two axis-aligned rectangles A and B.
// The output channel carries one word per result: an overlap flag, a tile and a
// last mark. A pair that only touches, or that yields no tile, gives exactly one
// word with overlap clear, zero tile fields and last set. A pair that overlaps
// gives one word per peeled tile, up to MAX_TILES, lowest and then leftmost
// first, and the final word carries last.
// Both channels use valid and stall; a word moves when valid is high and stall
// is low. The block takes one pair at a time: in_stall_o stays high from the
// cycle after acceptance until the final word of the pair has been loaded into
// the output register. That register lets the next pair be accepted while the
// final word still waits on a stalled receiver; a stalled receiver otherwise
// just holds the sequencer at its next word.
// The single read port of the vertex register file sets the run time. Each tile
// costs three descending scans, three ascending passes and five single states
// over the 8 to VERTEX_DEPTH stored vertices; a start with no partner costs two
// more descending scans and a search without a tile three. A touching pair skips
// the vertex store and goes straight to its final word.
// Reset clears the sequencer, the vertex count and the output valid.
module rect_pair_overlap_splitter_core #(
  parameter int VERTEX_DEPTH = 16,
  parameter int MAX_TILES    = 4,
  parameter int COORD_WIDTH  = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rpos_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rpos_pkg::out_word_t out_word_o
);
  import rpos_pkg::*;

  localparam int Cw   = COORD_WIDTH;
  localparam int Aw   = $clog2(VERTEX_DEPTH);
  localparam int CntW = $clog2(VERTEX_DEPTH + 1);
  localparam int TW   = $clog2(MAX_TILES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_PUSH, S_CROSS, S_LOW, S_LOWCHK, S_RIGHT, S_RIGHTCHK,
    S_TOP, S_CLR1, S_CLR2, S_UPD, S_PRES1, S_PRES2, S_TILE, S_FIN
  } state_e;

  state_e              state_q, state_d;
  logic [Aw-1:0]       idx_q, idx_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [2:0]          step_q, step_d;
  logic [TW-1:0]       ntile_q, ntile_d;
  logic                lv_ok_q, lv_ok_d, rv_ok_q, rv_ok_d, tv_ok_q, tv_ok_d;
  logic                found_q, found_d, pend_q, pend_d;
  logic [Aw-1:0]       lv_q, lv_d, rv_q, rv_d;
  logic signed [Cw-1:0] low_q, low_d, le_q, le_d, re_q, re_d, top_q, top_d;
  logic signed [Cw-1:0] al_q, al_d, ab_q, ab_d, ar_q, ar_d, at_q, at_d;
  logic signed [Cw-1:0] bl_q, bl_d, bb_q, bb_d, br_q, br_d, bt_q, bt_d;
  logic signed [Cw-1:0] pl_q, pl_d, pb_q, pb_d, pr_q, pr_d, pt_q, pt_d;
  logic                out_valid_q, out_valid_d;
  out_word_t           out_q, out_d;

  // Vertex store port signals.
  logic                 wr_xy_en, wr_cls_en;
  logic [Aw-1:0]        wr_addr;
  logic signed [Cw-1:0] wr_x, wr_y, rd_x, rd_y;
  cls_e                 wr_cls, rd_cls;

  // Point append request.
  logic                 push_en;
  logic signed [Cw-1:0] push_x, push_y;
  cls_e                 push_cls;

  logic [Aw-1:0]        cnt_last;
  logic                 out_free;
  logic signed [Cw:0]   xerr, yerr;
  logic signed [Cw-1:0] axlo, axhi, aylo, ayhi, bxlo, bxhi, bylo, byhi;
  logic signed [Cw-1:0] cvx, chy, cxlo, cxhi, cylo, cyhi;
  logic                 hit;

  rpos_vstore #(
    .Depth (VERTEX_DEPTH),
    .Cw    (Cw),
    .Aw    (Aw)
  ) u_vstore (
    .clk_i       (clk_i),
    .wr_xy_en_i  (wr_xy_en),
    .wr_cls_en_i (wr_cls_en),
    .wr_addr_i   (wr_addr),
    .wr_x_i      (wr_x),
    .wr_y_i      (wr_y),
    .wr_cls_i    (wr_cls),
    .rd_addr_i   (idx_q),
    .rd_x_o      (rd_x),
    .rd_y_o      (rd_y),
    .rd_cls_o    (rd_cls)
  );

  assign cnt_last = Aw'(cnt_q - CntW'(1));
  assign out_free = !out_valid_q || !out_stall_i;

  // Touch test: overlap extent along each axis, one bit wider than a coordinate.
  assign xerr = (al_q > bl_q) ? ((Cw+1)'(br_q) - (Cw+1)'(al_q))
                              : ((Cw+1)'(ar_q) - (Cw+1)'(bl_q));
  assign yerr = (ab_q > bb_q) ? ((Cw+1)'(bt_q) - (Cw+1)'(ab_q))
                              : ((Cw+1)'(at_q) - (Cw+1)'(bb_q));

  // Edge spans, each edge ordered on its own.
  assign axlo = (ar_q < al_q) ? ar_q : al_q;
  assign axhi = (ar_q < al_q) ? al_q : ar_q;
  assign aylo = (at_q < ab_q) ? at_q : ab_q;
  assign ayhi = (at_q < ab_q) ? ab_q : at_q;
  assign bxlo = (br_q < bl_q) ? br_q : bl_q;
  assign bxhi = (br_q < bl_q) ? bl_q : br_q;
  assign bylo = (bt_q < bb_q) ? bt_q : bb_q;
  assign byhi = (bt_q < bb_q) ? bb_q : bt_q;

  // Crossing candidates: every test is a point strictly inside an x span and a y span.
  always_comb begin
    cvx  = bl_q;
    chy  = at_q;
    cxlo = axlo;
    cxhi = axhi;
    cylo = bylo;
    cyhi = byhi;
    case (step_q)
      3'd0: begin cvx = bl_q; chy = at_q; end
      3'd1: begin cvx = bl_q; chy = ab_q; end
      3'd2: begin cvx = al_q; chy = bt_q; cxlo = bxlo; cxhi = bxhi; cylo = aylo; cyhi = ayhi; end
      3'd3: begin cvx = ar_q; chy = bt_q; cxlo = bxlo; cxhi = bxhi; cylo = aylo; cyhi = ayhi; end
      3'd4: begin cvx = br_q; chy = at_q; end
      3'd5: begin cvx = br_q; chy = ab_q; end
      3'd6: begin cvx = al_q; chy = bb_q; cxlo = bxlo; cxhi = bxhi; cylo = aylo; cyhi = ayhi; end
      3'd7: begin cvx = ar_q; chy = bb_q; cxlo = bxlo; cxhi = bxhi; cylo = aylo; cyhi = ayhi; end
      default: begin cvx = bl_q; end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    step_d      = step_q;
    ntile_d     = ntile_q;
    lv_ok_d     = lv_ok_q;
    rv_ok_d     = rv_ok_q;
    tv_ok_d     = tv_ok_q;
    found_d     = found_q;
    pend_d      = pend_q;
    lv_d        = lv_q;
    rv_d        = rv_q;
    low_d       = low_q;
    le_d        = le_q;
    re_d        = re_q;
    top_d       = top_q;
    al_d = al_q; ab_d = ab_q; ar_d = ar_q; at_d = at_q;
    bl_d = bl_q; bb_d = bb_q; br_d = br_q; bt_d = bt_q;
    pl_d = pl_q; pb_d = pb_q; pr_d = pr_q; pt_d = pt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    wr_xy_en    = 1'b0;
    wr_cls_en   = 1'b0;
    wr_addr     = idx_q;
    wr_x        = rd_x;
    wr_y        = rd_y;
    wr_cls      = CLS_NOTHING;
    push_en     = 1'b0;
    push_x      = ar_q;
    push_y      = ab_q;
    push_cls    = CLS_NOTHING;
    hit         = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          al_d = in_word_i.a_left[Cw-1:0];
          ab_d = in_word_i.a_bottom[Cw-1:0];
          ar_d = in_word_i.a_right[Cw-1:0];
          at_d = in_word_i.a_top[Cw-1:0];
          bl_d = in_word_i.b_left[Cw-1:0];
          bb_d = in_word_i.b_bottom[Cw-1:0];
          br_d = in_word_i.b_right[Cw-1:0];
          bt_d = in_word_i.b_top[Cw-1:0];
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        pend_d  = 1'b0;
        ntile_d = '0;
        if (xerr[Cw] || (xerr == '0) || yerr[Cw] || (yerr == '0)) begin
          state_d = S_FIN;
        end else begin
          cnt_d   = '0;
          step_d  = '0;
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        // Corners of A, then B: lower right, upper right, upper left, lower left.
        push_en  = 1'b1;
        push_x   = step_q[2] ? ((step_q[1]) ? bl_q : br_q) : ((step_q[1]) ? al_q : ar_q);
        push_y   = step_q[2] ? ((step_q[1:0] == 2'd0 || step_q[1:0] == 2'd3) ? bb_q : bt_q)
                             : ((step_q[1:0] == 2'd0 || step_q[1:0] == 2'd3) ? ab_q : at_q);
        push_cls = (step_q[1:0] == 2'd0) ? CLS_END :
                   (step_q[1:0] == 2'd3) ? CLS_START : CLS_NOTHING;
        step_d   = step_q + 3'd1;
        if (step_q == 3'd7) begin
          state_d = S_CROSS;
        end
      end
      S_CROSS: begin
        push_en = (cxlo < cvx) && (cvx < cxhi) && (cylo < chy) && (chy < cyhi);
        push_x  = cvx;
        push_y  = chy;
        step_d  = step_q + 3'd1;
        if (step_q == 3'd7) begin
          lv_ok_d = 1'b0;
          idx_d   = Aw'(cnt_q + CntW'(push_en && (cnt_q < CntW'(VERTEX_DEPTH))) - CntW'(1));
          state_d = S_LOW;
        end
      end
      S_LOW: begin
        hit = (rd_cls == CLS_START) &&
              (!lv_ok_q || (rd_y < low_q) || ((rd_y == low_q) && (rd_x < le_q)));
        if (hit) begin
          lv_ok_d = 1'b1;
          lv_d    = idx_q;
          low_d   = rd_y;
          le_d    = rd_x;
        end
        idx_d = idx_q - Aw'(1);
        if (idx_q == '0) begin
          state_d = S_LOWCHK;
        end
      end
      S_LOWCHK: begin
        if (!lv_ok_q) begin
          state_d = S_FIN;
        end else begin
          rv_ok_d = 1'b0;
          idx_d   = cnt_last;
          state_d = S_RIGHT;
        end
      end
      S_RIGHT: begin
        hit = (rd_cls == CLS_END) && (rd_y == low_q) && (rd_x >= le_q) &&
              (!rv_ok_q || (rd_x > re_q));
        if (hit) begin
          rv_ok_d = 1'b1;
          rv_d    = idx_q;
          re_d    = rd_x;
        end
        idx_d = idx_q - Aw'(1);
        if (idx_q == '0) begin
          state_d = S_RIGHTCHK;
        end
      end
      S_RIGHTCHK: begin
        if (!rv_ok_q) begin
          // No partner on the start's row: retire the start and search again.
          wr_cls_en = 1'b1;
          wr_addr   = lv_q;
          lv_ok_d   = 1'b0;
          idx_d     = cnt_last;
          state_d   = S_LOW;
        end else begin
          tv_ok_d = 1'b0;
          idx_d   = cnt_last;
          state_d = S_TOP;
        end
      end
      S_TOP: begin
        hit = (rd_x >= le_q) && (rd_x <= re_q) && (rd_y > low_q) &&
              (!tv_ok_q || (rd_y < top_q));
        if (hit) begin
          tv_ok_d = 1'b1;
          top_d   = rd_y;
        end
        idx_d = idx_q - Aw'(1);
        if (idx_q == '0) begin
          state_d = S_CLR1;
        end
      end
      S_CLR1: begin
        wr_cls_en = 1'b1;
        wr_addr   = lv_q;
        state_d   = S_CLR2;
      end
      S_CLR2: begin
        wr_cls_en = 1'b1;
        wr_addr   = rv_q;
        if (!tv_ok_q || (le_q == re_q)) begin
          lv_ok_d = 1'b0;
          idx_d   = cnt_last;
          state_d = S_LOW;
        end else begin
          idx_d   = '0;
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        // Raise the starts and ends covered by the new tile to its top.
        hit = (low_q <= rd_y) && (rd_y < top_q) &&
              (((rd_cls == CLS_START) && (le_q <= rd_x) && (rd_x < re_q)) ||
               ((rd_cls == CLS_END) && (le_q < rd_x) && (rd_x <= re_q)));
        wr_xy_en = hit;
        wr_y     = top_q;
        idx_d    = idx_q + Aw'(1);
        if (idx_q == cnt_last) begin
          idx_d   = '0;
          found_d = 1'b0;
          state_d = S_PRES1;
        end
      end
      S_PRES1: begin
        hit     = (rd_x == le_q) && (rd_y == top_q);
        found_d = found_q || hit;
        idx_d   = idx_q + Aw'(1);
        if (idx_q == cnt_last) begin
          push_en  = !(found_q || hit);
          push_x   = le_q;
          push_y   = top_q;
          push_cls = CLS_START;
          idx_d    = '0;
          found_d  = 1'b0;
          state_d  = S_PRES2;
        end
      end
      S_PRES2: begin
        hit     = (rd_x == re_q) && (rd_y == top_q);
        found_d = found_q || hit;
        idx_d   = idx_q + Aw'(1);
        if (idx_q == cnt_last) begin
          push_en  = !(found_q || hit);
          push_x   = re_q;
          push_y   = top_q;
          push_cls = CLS_END;
          state_d  = S_TILE;
        end
      end
      S_TILE: begin
        // The previous tile is sent only once a further tile proves it is not last.
        if (!pend_q || out_free) begin
          if (pend_q) begin
            out_valid_d       = 1'b1;
            out_d.overlap     = 1'b1;
            out_d.tile_left   = 32'(pl_q);
            out_d.tile_bottom = 32'(pb_q);
            out_d.tile_right  = 32'(pr_q);
            out_d.tile_top    = 32'(pt_q);
            out_d.last        = 1'b0;
          end
          pend_d  = 1'b1;
          pl_d    = le_q;
          pb_d    = low_q;
          pr_d    = re_q;
          pt_d    = top_q;
          ntile_d = ntile_q + TW'(1);
          if (ntile_q == TW'(MAX_TILES - 1)) begin
            state_d = S_FIN;
          end else begin
            lv_ok_d = 1'b0;
            idx_d   = cnt_last;
            state_d = S_LOW;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.overlap     = pend_q;
          out_d.tile_left   = pend_q ? 32'(pl_q) : '0;
          out_d.tile_bottom = pend_q ? 32'(pb_q) : '0;
          out_d.tile_right  = pend_q ? 32'(pr_q) : '0;
          out_d.tile_top    = pend_q ? 32'(pt_q) : '0;
          out_d.last        = 1'b1;
          pend_d            = 1'b0;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Append a point at the end of the store; a full store drops it.
    if (push_en && (cnt_q < CntW'(VERTEX_DEPTH))) begin
      wr_xy_en  = 1'b1;
      wr_cls_en = 1'b1;
      wr_addr   = cnt_q[Aw-1:0];
      wr_x      = push_x;
      wr_y      = push_y;
      wr_cls    = push_cls;
      cnt_d     = cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    step_q  <= step_d;
    ntile_q <= ntile_d;
    lv_ok_q <= lv_ok_d;
    rv_ok_q <= rv_ok_d;
    tv_ok_q <= tv_ok_d;
    found_q <= found_d;
    lv_q    <= lv_d;
    rv_q    <= rv_d;
    low_q   <= low_d;
    le_q    <= le_d;
    re_q    <= re_d;
    top_q   <= top_d;
    al_q <= al_d; ab_q <= ab_d; ar_q <= ar_d; at_q <= at_d;
    bl_q <= bl_d; bb_q <= bb_d; br_q <= br_d; bt_q <= bt_d;
    pl_q <= pl_d; pb_q <= pb_d; pr_q <= pr_d; pt_q <= pt_d;
    out_q   <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

### verif/rect_pair_overlap_splitter_core_test.sv
// Testbench for the rectangle pair overlap splitter core: directed and random pairs.
module rect_pair_overlap_splitter_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rpos_pkg::*;

  localparam int VDEPTH = 16;
  localparam int TILE_CAP = 4;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_word_t in_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_word_t out_word_o;

  rect_pair_overlap_splitter_core dut (.*);

  // Clock with a 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Percentages of idling on each side, changed from phase to phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  // While this counter is nonzero the receiver holds off for a long stretch.
  int unsigned hold_cycles = 0;
  int unsigned failures = 0;
  int unsigned cycle_count = 0;

  // Expected result words, oldest first.
  out_word_t tile_queue[$];

  // The predictor keeps its own vertex store, as the block does.
  typedef struct {
    longint px;
    longint py;
    cls_e cls;
  } vtx_t;
  vtx_t vstore[VDEPTH];
  int vcount = 0;

  function automatic void add_vertex(longint x, longint y, cls_e c);
    if (vcount >= VDEPTH) return;
    vstore[vcount].px = x;
    vstore[vcount].py = y;
    vstore[vcount].cls = c;
    vcount++;
  endfunction

  function automatic void add_rect(longint l, longint b, longint r, longint t);
    add_vertex(r, b, CLS_END);
    add_vertex(r, t, CLS_NOTHING);
    add_vertex(l, t, CLS_NOTHING);
    add_vertex(l, b, CLS_START);
  endfunction

  function automatic void sort_pair(ref longint lo, ref longint hi);
    longint k;
    if (hi < lo) begin
      k = lo;
      lo = hi;
      hi = k;
    end
  endfunction

  // Points where the edges of the newer rectangle cross those of the older one.
  function automatic void add_edge_crossings();
    longint cx[8];
    longint cy[8];
    longint x1, y1, x2, y2, x3, y3, x4, y4;
    int n, k;
    n = 0;
    for (int i = vcount - 1; i >= 0 && n < 8; i--) begin
      cx[n] = vstore[i].px;
      cy[n] = vstore[i].py;
      n++;
    end
    if (n < 8) return;
    for (int i = 0; i < 4; i++) begin
      for (int j = ((i & 1) ? 4 : 5); j <= 7; j += 2) begin
        x1 = cx[i]; y1 = cy[i];
        x2 = cx[(i + 1) & 3]; y2 = cy[(i + 1) & 3];
        sort_pair(x1, x2);
        sort_pair(y1, y2);
        k = (j == 7) ? 4 : j + 1;
        x3 = cx[j]; y3 = cy[j]; x4 = cx[k]; y4 = cy[k];
        sort_pair(x3, x4);
        sort_pair(y3, y4);
        if ((i & 1) == 0) begin
          if (x3 < x1 && x1 < x4 && y1 < y3 && y3 < y2) add_vertex(x1, y3, CLS_NOTHING);
        end else begin
          if (x1 < x3 && x3 < x2 && y3 < y1 && y1 < y4) add_vertex(x3, y2, CLS_NOTHING);
        end
      end
    end
  endfunction

  function automatic bit has_vertex(longint x, longint y);
    for (int i = 0; i < vcount; i++)
      if (vstore[i].px == x && vstore[i].py == y) return 1'b1;
    return 1'b0;
  endfunction

  // Peels off the next tile: lowest then leftmost start corner, widest end corner
  // on its row, and the nearest vertex above the span. Ties go to the newest entry.
  function automatic bit peel_tile(output longint tl, output longint tb,
                                   output longint tr, output longint tt);
    int lv, rv, tv;
    longint low, le, re, top;
    tl = 0; tb = 0; tr = 0; tt = 0;
    forever begin
      lv = -1; rv = -1; tv = -1;
      low = 0; le = 0; re = 0; top = 0;
      for (int i = vcount - 1; i >= 0; i--) begin
        if (vstore[i].cls != CLS_START) continue;
        if (lv < 0 || vstore[i].py < low || (vstore[i].py == low && vstore[i].px < le)) begin
          lv = i; low = vstore[i].py; le = vstore[i].px;
        end
      end
      if (lv < 0) return 1'b0;
      for (int i = vcount - 1; i >= 0; i--) begin
        if (vstore[i].cls == CLS_END && vstore[i].py == low && vstore[i].px >= le &&
            (rv < 0 || vstore[i].px > re)) begin
          rv = i; re = vstore[i].px;
        end
      end
      if (rv < 0) begin
        vstore[lv].cls = CLS_NOTHING;
        continue;
      end
      for (int i = vcount - 1; i >= 0; i--) begin
        if (vstore[i].px >= le && vstore[i].px <= re && vstore[i].py > low &&
            (tv < 0 || vstore[i].py < top)) begin
          tv = i; top = vstore[i].py;
        end
      end
      vstore[lv].cls = CLS_NOTHING;
      vstore[rv].cls = CLS_NOTHING;
      if (tv < 0 || le == re) continue;
      for (int i = 0; i < vcount; i++) begin
        if (vstore[i].cls == CLS_START && le <= vstore[i].px && vstore[i].px < re &&
            low <= vstore[i].py && vstore[i].py < top) vstore[i].py = top;
        if (vstore[i].cls == CLS_END && le < vstore[i].px && vstore[i].px <= re &&
            low <= vstore[i].py && vstore[i].py < top) vstore[i].py = top;
      end
      if (!has_vertex(le, top)) add_vertex(le, top, CLS_START);
      if (!has_vertex(re, top)) add_vertex(re, top, CLS_END);
      tl = le; tb = low; tr = re; tt = top;
      return 1'b1;
    end
  endfunction

  // Works out the result words of one pair and queues them.
  function automatic void predict_tiles(in_word_t w);
    longint al, ab, ar, at, bl, bb, br, bt, xs, ys;
    longint tl, tb, tr, tt;
    out_word_t o;
    out_word_t found[$];
    al = w.a_left; ab = w.a_bottom; ar = w.a_right; at = w.a_top;
    bl = w.b_left; bb = w.b_bottom; br = w.b_right; bt = w.b_top;
    xs = (al > bl) ? br - al : ar - bl;
    ys = (ab > bb) ? bt - ab : at - bb;
    o = '0;
    o.last = 1'b1;
    if (xs <= 0 || ys <= 0) begin
      tile_queue.push_back(o);
      return;
    end
    vcount = 0;
    add_rect(al, ab, ar, at);
    add_rect(bl, bb, br, bt);
    add_edge_crossings();
    while (found.size() < TILE_CAP && peel_tile(tl, tb, tr, tt)) begin
      o.overlap = 1'b1;
      o.tile_left = tl[31:0];
      o.tile_bottom = tb[31:0];
      o.tile_right = tr[31:0];
      o.tile_top = tt[31:0];
      o.last = 1'b0;
      found.push_back(o);
    end
    if (found.size() == 0) begin
      o = '0;
      o.last = 1'b1;
      tile_queue.push_back(o);
      return;
    end
    found[found.size() - 1].last = 1'b1;
    foreach (found[i]) tile_queue.push_back(found[i]);
  endfunction

  // Offers one word with random gaps and waits until it is taken. Valid is
  // dropped by the next idle cycle or by the drain, so it gets one update per edge.
  task automatic send_pair(in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_tiles(w);
  endtask

  // Receiver stall pattern, including the long hold-off.
  always @(posedge clk_i) begin
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Compares every accepted result word with the oldest expectation.
  always @(posedge clk_i) begin
    out_word_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (tile_queue.size() == 0) begin
        $display("%0t: unexpected word %p", $time, out_word_o);
        failures++;
      end else begin
        e = tile_queue.pop_front();
        if (out_word_o.overlap !== e.overlap || out_word_o.tile_left !== e.tile_left ||
            out_word_o.tile_bottom !== e.tile_bottom ||
            out_word_o.tile_right !== e.tile_right ||
            out_word_o.tile_top !== e.tile_top || out_word_o.last !== e.last) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, out_word_o);
          failures++;
        end
      end
    end
  end

  // Watchdog on the total run time.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("rect_pair_overlap_splitter_core test failed");
      $finish;
    end
  end

  function automatic in_word_t make_pair(int l0, int b0, int r0, int t0,
                                         int l1, int b1, int r1, int t1);
    in_word_t w;
    w.a_left = l0; w.a_bottom = b0; w.a_right = r0; w.a_top = t0;
    w.b_left = l1; w.b_bottom = b1; w.b_right = r1; w.b_top = t1;
    return w;
  endfunction

  // Small coordinates make overlaps and crossings common.
  function automatic int near_coord(int base);
    return base + $signed($urandom_range(20)) - 10;
  endfunction

  function automatic in_word_t random_pair();
    in_word_t w;
    int cx, cy, l, b;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8) begin
      w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      // Rectangles around a shared, sometimes extreme, center; B is sometimes inverted.
      cx = (pick < 20) ? $urandom : $signed($urandom_range(200)) - 100;
      cy = (pick < 20) ? $urandom : $signed($urandom_range(200)) - 100;
      l = near_coord(cx); b = near_coord(cy);
      w.a_left = l; w.a_bottom = b;
      w.a_right = l + $urandom_range(15); w.a_top = b + $urandom_range(15);
      l = near_coord(cx); b = near_coord(cy);
      w.b_left = l; w.b_bottom = b;
      w.b_right = l + $urandom_range(15); w.b_top = b + $urandom_range(15);
      if (pick > 94) w.b_right = w.b_left - $urandom_range(5);  // inverted
    end
    return w;
  endfunction

  // Waits until every expected word has arrived.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (tile_queue.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic test_directed();
    int mx, mn;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    send_pair(make_pair(0, 0, 10, 10, 10, 0, 20, 10));     // touching on x
    send_pair(make_pair(0, 0, 10, 10, 0, 10, 10, 20));     // touching on y
    send_pair(make_pair(0, 0, 10, 10, 30, 30, 40, 40));    // apart
    send_pair(make_pair(0, 0, 10, 10, 0, 0, 10, 10));      // identical
    send_pair(make_pair(0, 0, 10, 10, 5, 5, 15, 15));      // corner overlap
    send_pair(make_pair(0, 0, 20, 20, 5, 5, 15, 15));      // containment
    send_pair(make_pair(5, 0, 10, 20, 0, 5, 20, 10));      // cross, edges crossing
    send_pair(make_pair(0, 0, 20, 10, 5, -5, 15, 15));     // vertical band through
    send_pair(make_pair(5, 5, 15, 15, 0, 0, 10, 10));      // swapped order
    send_pair(make_pair(10, 10, 0, 0, 5, 5, 15, 15));      // inverted rectangle
    send_pair(make_pair(0, 0, 0, 10, -5, 0, 5, 10));       // degenerate width
    send_pair(make_pair(mn, mn, mx, mx, mn, mn, mx, mx));  // full range
    send_pair(make_pair(mn, mn, mn + 4, mn + 4, mn + 2, mn + 2, mn + 6, mn + 6));
    send_pair(make_pair(mx - 6, mx - 6, mx - 2, mx - 2, mx - 4, mx - 4, mx, mx));
    send_pair(make_pair(-1, -1, 0, 0, -1, -1, 0, 0));
    send_pair(make_pair(mx, mn, mn, mx, mn, mx, mx, mn));  // extremes inverted
    send_pair(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));  // every bit set
    drain_results();
  endtask

  task automatic test_random(int unsigned count, int unsigned sidle, int unsigned rstall);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    repeat (count) send_pair(random_pair());
    drain_results();
  endtask

  // The receiver holds off while pairs keep coming, so the block backs up.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 3000;
    repeat (12) send_pair(random_pair());
    drain_results();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(110, 0, 0);
    test_random(110, 56, 0);
    test_random(110, 0, 56);
    test_random(110, 37, 37);
    test_backpressure();
    if (failures == 0) begin
      $display("rect_pair_overlap_splitter_core test passed");
    end else begin
      $display("rect_pair_overlap_splitter_core test failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/rpos_pkg.sv
rtl/core/rpos_vstore.sv
rtl/core/rect_pair_overlap_splitter_core.sv
verif/rect_pair_overlap_splitter_core_test.sv
